// ===== hdl/chbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbp_pkg: shared types and constants for the click to hue/brightness mapper
// Angle table, register indexes, axis codes and fixed output values.
// ----------------------------------------------------------------------------
package chbp_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int EDGE_MARGIN_DEF   = 2;
	localparam int TAB_LEN           = 24;

	// atan(2^-i) * 2^31 / pi
	localparam logic [31:0] TURN_TAB [TAB_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic signed [33:0] Z_HALF = 34'sh080000000;

	localparam logic [14:0] HUE_CENTER = 15'd12288;
	localparam logic [14:0] HUE_YPOS   = 15'd18432;
	localparam logic [14:0] HUE_YNEG   = 15'd6144;
	localparam logic [14:0] HUE_XPOS   = 15'd12288;
	localparam logic [14:0] HUE_XNEG   = 15'd24576;
	localparam logic [14:0] HUE_MAX    = 15'd24576;

	localparam logic [12:0] BRIGHT_FULL = 13'd4096;

	localparam logic [10:0] CENTER_X_RST = 11'd100;
	localparam logic [10:0] CENTER_Y_RST = 11'd100;
	localparam logic [11:0] DIAMETER_RST = 12'd200;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_DIAMETER = 2'd2
	} chbp_reg_t;

	typedef enum logic [2:0] {
		SPEC_NONE,
		SPEC_CENTER,
		SPEC_YPOS,
		SPEC_YNEG,
		SPEC_XPOS,
		SPEC_XNEG
	} chbp_spec_t;

	typedef struct packed {
		logic reject;
		logic rim;
	} chbp_flags_t;

endpackage

// ===== hdl/click_to_hue_brightness_polar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// click_to_hue_brightness_polar: pointer position to hue and brightness
// Maps a click on a color disc to polar form: CORDIC angle for hue,
// bit-serial square root and restoring divider for brightness.
// ----------------------------------------------------------------------------
//  channel  dir  beat content
//  s_*      in   click_x, click_y
//  m_*      out  hue, brightness (tdata), inside_res (tuser)
//  cfg_*    in   register index and write data
//
//  One beat is accepted every cycle while the output beat is not held.
//  The pipeline depth is set by the 24-stage square root and 12-stage divider.
//  Reset clears all valid bits and loads the disc registers to 100/100/200.
//  A held output beat freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module click_to_hue_brightness_polar #(
	parameter int CORDIC_STAGES = chbp_pkg::CORDIC_STAGES_DEF,
	parameter int EDGE_MARGIN   = chbp_pkg::EDGE_MARGIN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // click_x[11:0], click_y[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // hue[14:0], brightness[27:15], zero[31:28]
	output logic [0:0]  m_tuser,   // inside_res[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int N      = (CORDIC_STAGES > chbp_pkg::TAB_LEN) ?
	                        chbp_pkg::TAB_LEN : CORDIC_STAGES;
	localparam int LAT    = 41;
	localparam int LIM_W  = $clog2(4095 + 2 * EDGE_MARGIN + 1);
	localparam int LIM_W2 = 2 * LIM_W;
	localparam int CW     = 27;

	// configuration
	logic [10:0]       cx_q;
	logic [10:0]       cy_q;
	logic [11:0]       dd_q;
	logic [23:0]       d_sq_q;
	logic [LIM_W2-1:0] lim_sq_q;
	logic [LIM_W-1:0]  lim;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= chbp_pkg::CENTER_X_RST;
			cy_q <= chbp_pkg::CENTER_Y_RST;
			dd_q <= chbp_pkg::DIAMETER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (chbp_pkg::chbp_reg_t'(cfg_index))
				chbp_pkg::REG_CENTER_X: cx_q <= cfg_data[10:0];
				chbp_pkg::REG_CENTER_Y: cy_q <= cfg_data[10:0];
				chbp_pkg::REG_DIAMETER: dd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lim = LIM_W'(dd_q) + LIM_W'(2 * EDGE_MARGIN);

	always_ff @(posedge clk) begin
		d_sq_q   <= 24'(dd_q) * 24'(dd_q);
		lim_sq_q <= LIM_W2'(lim) * LIM_W2'(lim);
	end

	// pipeline control
	logic [LAT:1] vld_q;
	logic         en;

	assign en       = !vld_q[LAT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], s_tvalid};
		end
	end

	// stage 1: offsets
	logic signed [12:0] dx_s1;
	logic signed [12:0] dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({2'b00, cx_q} - {1'b0, s_tdata[11:0]});
			dy_s1 <= $signed({2'b00, cy_q} - {1'b0, s_tdata[23:12]});
		end
	end

	// stage 2: squares
	logic signed [25:0] px;
	logic signed [25:0] py;
	logic [23:0]        sqx_s2;
	logic [23:0]        sqy_s2;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= px[23:0];
			sqy_s2 <= py[23:0];
		end
	end

	// stage 3: squared radius
	logic [24:0] r2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

	// stage 4: range checks, square root seed (arrays indexed by stage)
	logic [CW-1:0]         fourr;
	chbp_pkg::chbp_flags_t flag_sn [4:40];
	logic [21:0]           rad_sn  [4:27];
	logic [25:0]           rem_sn  [4:28];
	logic [23:0]           root_sn [4:28];

	assign fourr = {r2_s3, 2'b00};

	always_ff @(posedge clk) begin
		if (en) begin
			flag_sn[4].reject <= fourr > CW'(lim_sq_q);
			flag_sn[4].rim    <= fourr >= CW'(d_sq_q);
			rad_sn[4]         <= r2_s3[21:0];
			rem_sn[4]         <= '0;
			root_sn[4]        <= '0;
		end
	end

	for (genvar k = 5; k <= 40; k++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				flag_sn[k] <= flag_sn[k-1];
			end
		end
	end

	// stages 5..28: square root of r2 * 2^26, one root bit per stage
	for (genvar k = 5; k <= 28; k++) begin : g_sqrt
		logic [27:0] ext;
		logic [27:0] trial;

		assign ext   = {rem_sn[k-1], rad_sn[k-1][21:20]};
		assign trial = {2'b00, root_sn[k-1], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (ext >= trial) begin
					rem_sn[k]  <= 26'(ext - trial);
					root_sn[k] <= {root_sn[k-1][22:0], 1'b1};
				end else begin
					rem_sn[k]  <= ext[25:0];
					root_sn[k] <= {root_sn[k-1][22:0], 1'b0};
				end
			end
		end

		if (k < 28) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_sn[k] <= {rad_sn[k-1][19:0], 2'b00};
				end
			end
		end
	end

	// stages 29..40: root / diameter, one quotient bit per stage
	logic [23:0] drem_sn [29:40];
	logic [11:0] quo_sn  [29:40];

	for (genvar k = 29; k <= 40; k++) begin : g_div
		logic [23:0] din;
		logic [11:0] qin;
		logic [23:0] dsh;

		if (k == 29) begin : g_first
			assign din = root_sn[28];
			assign qin = '0;
		end else begin : g_next
			assign din = drem_sn[k-1];
			assign qin = quo_sn[k-1];
		end

		assign dsh = {12'd0, dd_q} << (40 - k);

		always_ff @(posedge clk) begin
			if (en) begin
				if (din >= dsh) begin
					drem_sn[k] <= din - dsh;
					quo_sn[k]  <= {qin[10:0], 1'b1};
				end else begin
					drem_sn[k] <= din;
					quo_sn[k]  <= {qin[10:0], 1'b0};
				end
			end
		end
	end

	// stage 2: CORDIC pre-rotation and axis codes
	logic signed [31:0]   cx_sn   [2:N+2];
	logic signed [31:0]   cy_sn   [2:N+2];
	logic signed [33:0]   cz_sn   [2:N+2];
	chbp_pkg::chbp_spec_t spec_sn [2:N+3];
	logic signed [31:0]   x0;
	logic signed [31:0]   y0;
	chbp_pkg::chbp_spec_t spec0;

	assign x0 = {{3{dx_s1[12]}}, dx_s1, 16'h0000};
	assign y0 = {{3{dy_s1[12]}}, dy_s1, 16'h0000};

	always_comb begin
		spec0 = chbp_pkg::SPEC_NONE;
		if (dx_s1 == 13'sd0 && dy_s1 == 13'sd0) begin
			spec0 = chbp_pkg::SPEC_CENTER;
		end else if (dx_s1 == 13'sd0) begin
			spec0 = dy_s1[12] ? chbp_pkg::SPEC_YNEG : chbp_pkg::SPEC_YPOS;
		end else if (dy_s1 == 13'sd0) begin
			spec0 = dx_s1[12] ? chbp_pkg::SPEC_XNEG : chbp_pkg::SPEC_XPOS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_sn[2] <= spec0;
			if (dx_s1[12]) begin
				cx_sn[2] <= -x0;
				cy_sn[2] <= -y0;
				cz_sn[2] <= dy_s1[12] ? -chbp_pkg::Z_HALF : chbp_pkg::Z_HALF;
			end else begin
				cx_sn[2] <= x0;
				cy_sn[2] <= y0;
				cz_sn[2] <= '0;
			end
		end
	end

	// stages 3..N+2: CORDIC vectoring
	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [31:0] xs;
		logic signed [31:0] ys;
		logic signed [33:0] tv;

		assign xs = cx_sn[2+i] >>> i;
		assign ys = cy_sn[2+i] >>> i;
		assign tv = $signed({2'b00, chbp_pkg::TURN_TAB[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				spec_sn[3+i] <= spec_sn[2+i];
				if (!cy_sn[2+i][31]) begin
					cx_sn[3+i] <= cx_sn[2+i] + ys;
					cy_sn[3+i] <= cy_sn[2+i] - xs;
					cz_sn[3+i] <= cz_sn[2+i] + tv;
				end else begin
					cx_sn[3+i] <= cx_sn[2+i] - ys;
					cy_sn[3+i] <= cy_sn[2+i] + xs;
					cz_sn[3+i] <= cz_sn[2+i] - tv;
				end
			end
		end
	end

	// stage N+3: scale angle to hue
	logic signed [35:0] zw;
	logic signed [35:0] tsum_sn;

	assign zw = {{2{cz_sn[N+2][33]}}, cz_sn[N+2]} + 36'sh080000000;

	always_ff @(posedge clk) begin
		if (en) begin
			tsum_sn      <= (zw <<< 1) + zw + 36'sd262144;
			spec_sn[N+3] <= spec_sn[N+2];
		end
	end

	// stage N+4: clamp, axis override; then delay to stage 40
	logic [14:0] hue_sn [N+4:40];
	logic [15:0] hsh;
	logic [14:0] hcl;

	assign hsh = tsum_sn[34:19];

	always_comb begin
		if (tsum_sn[35]) begin
			hcl = '0;
		end else if (hsh > {1'b0, chbp_pkg::HUE_MAX}) begin
			hcl = chbp_pkg::HUE_MAX;
		end else begin
			hcl = hsh[14:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (spec_sn[N+3])
				chbp_pkg::SPEC_CENTER: hue_sn[N+4] <= chbp_pkg::HUE_CENTER;
				chbp_pkg::SPEC_YPOS:   hue_sn[N+4] <= chbp_pkg::HUE_YPOS;
				chbp_pkg::SPEC_YNEG:   hue_sn[N+4] <= chbp_pkg::HUE_YNEG;
				chbp_pkg::SPEC_XPOS:   hue_sn[N+4] <= chbp_pkg::HUE_XPOS;
				chbp_pkg::SPEC_XNEG:   hue_sn[N+4] <= chbp_pkg::HUE_XNEG;
				default:               hue_sn[N+4] <= hcl;
			endcase
		end
	end

	for (genvar k = N + 5; k <= 40; k++) begin : g_hue_dly
		always_ff @(posedge clk) begin
			if (en) begin
				hue_sn[k] <= hue_sn[k-1];
			end
		end
	end

	// stage 41: output beat
	logic        inside_s41;
	logic [14:0] hue_s41;
	logic [12:0] bright_s41;

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s41 <= !flag_sn[40].reject;
			if (flag_sn[40].reject) begin
				hue_s41    <= '0;
				bright_s41 <= '0;
			end else begin
				hue_s41    <= hue_sn[40];
				bright_s41 <= flag_sn[40].rim ? chbp_pkg::BRIGHT_FULL : {1'b0, quo_sn[40]};
			end
		end
	end

	assign m_tdata = {4'b0000, bright_s41, hue_s41};
	assign m_tuser = inside_s41;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("rejected beat carries nonzero hue or brightness");

	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[27:15] <= chbp_pkg::BRIGHT_FULL)
		else $error("brightness above full scale");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:0] <= chbp_pkg::HUE_MAX)
		else $error("hue above full turn");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:28] == 4'd0)
		else $error("tdata padding not zero");

endmodule
